// File: hdl/cclb_pkg.sv
// Shared constants, character codes and interface types for the C++ comment
// and literal blanker. No dependencies; every other file imports this package.
`default_nettype none

package cclb_pkg;

  // Longest raw string delimiter that is stored and matched.
  localparam int MAX_DELIM = 16;
  // Closer window: ')' + delimiter + '"'.
  localparam int WIN_DEPTH = MAX_DELIM + 2;
  localparam int DLEN_W    = $clog2(MAX_DELIM + 1);
  localparam int WCNT_W    = $clog2(WIN_DEPTH + 1);
  localparam int WIDX_W    = $clog2(WIN_DEPTH);

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SP     = 8'h20;
  localparam logic [7:0] CH_DQ     = 8'h22;
  localparam logic [7:0] CH_SQ     = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_R      = 8'h52;
  localparam logic [7:0] CH_UZ     = 8'h5A;
  localparam logic [7:0] CH_BSL    = 8'h5C;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LZ     = 8'h7A;

  // Per-cell controls from the chain wrapper.
  typedef struct packed {
    logic win_sh;
    logic dlm_sh;
    logic is_dlm;
    logic is_par;
  } cclb_cell_ctl_t;

  // Lexer to cell chain.
  typedef struct packed {
    logic              win_sh;
    logic              dlm_sh;
    logic [7:0]        dat;
    logic [DLEN_W-1:0] dlen;
    logic [WCNT_W-1:0] wcnt;
  } cclb_chain_ctl_t;

  // Cell chain to lexer.
  typedef struct packed {
    logic       all_ok;
    logic [7:0] par_dat;
    logic [7:0] rd_dat;
  } cclb_chain_sts_t;

  // One output byte from the lexer towards the output register.
  typedef struct packed {
    logic       vld;
    logic [7:0] dat;
    logic       last;
    logic       ovf;
  } cclb_emit_t;

endpackage

`default_nettype wire

// File: hdl/cpp_comment_literal_blanker.sv
// Throughput: one output byte per cycle while the output register is free. A one-byte item is
// a single step, a comment opener or escape emits two spaces, a raw string closer match has a
// matching step and then drains the whole closer, and the final item additionally its second
// call and the window flush. The lexer sequencer sets this.
// Reset: synchronous, active low, back to code mode; the state also clears after the last item.
`default_nettype none

module cpp_comment_literal_blanker import cclb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic       out_delim_overflow
);

  cclb_chain_ctl_t chain_ctl;
  cclb_chain_sts_t chain_sts;
  cclb_emit_t      em;

  logic       acc;
  logic       out_free;
  logic       out_v_r;
  logic [7:0] out_byte_r;
  logic       out_last_r;
  logic       out_ovf_r;

  assign acc      = in_valid && !in_stall;
  assign out_free = !out_v_r || !out_stall;

  cclb_lexer u_lexer (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (acc),
    .acc_byte   (in_byte),
    .acc_last   (in_last),
    .item_stall (in_stall),
    .out_free   (out_free),
    .chain_ctl  (chain_ctl),
    .chain_sts  (chain_sts),
    .emit_o     (em)
  );

  cclb_chain u_chain (
    .clk (clk),
    .ctl (chain_ctl),
    .sts (chain_sts)
  );

  // Output register parts the lexer from the downstream stall.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_free) begin
      out_v_r <= em.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && em.vld) begin
      out_byte_r <= em.dat;
      out_last_r <= em.last;
      out_ovf_r  <= em.ovf;
    end
  end

  assign out_valid          = out_v_r;
  assign out_byte           = out_byte_r;
  assign out_last           = out_last_r;
  assign out_delim_overflow = out_ovf_r;

endmodule

`default_nettype wire

// File: hdl/cclb_cell.sv
// One cell of the raw string closer chain: a window byte and a delimiter byte,
// each shifted in from the neighbouring cell, plus the local closer compare.
// Depends on cclb_pkg.
`default_nettype none

module cclb_cell import cclb_pkg::*; (
  input  logic           clk,
  input  cclb_cell_ctl_t ctl,
  input  logic [7:0]     win_in,
  input  logic [7:0]     dlm_in,
  output logic [7:0]     win_q,
  output logic [7:0]     dlm_q,
  output logic           ok
);

  logic [7:0] win_r;
  logic [7:0] win_nxt;
  logic [7:0] dlm_r;
  logic [7:0] dlm_nxt;

  always_comb begin
    win_nxt = ctl.win_sh ? win_in : win_r;
    dlm_nxt = ctl.dlm_sh ? dlm_in : dlm_r;
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
    dlm_r <= dlm_nxt;
  end

  // Inside the delimiter the window byte must equal the stored delimiter
  // byte; the cell just past it must hold the closing parenthesis.
  always_comb begin
    if (ctl.is_dlm) begin
      ok = (win_r == dlm_r);
    end else if (ctl.is_par) begin
      ok = (win_r == CH_RPAREN);
    end else begin
      ok = 1'b1;
    end
  end

  assign win_q = win_r;
  assign dlm_q = dlm_r;

endmodule

`default_nettype wire

// File: hdl/cclb_chain.sv
// Row of closer cells, newest byte in cell 0, with the match reduction and the
// read selects for the oldest window byte. Depends on cclb_pkg and cclb_cell.
`default_nettype none

module cclb_chain import cclb_pkg::*; (
  input  logic            clk,
  input  cclb_chain_ctl_t ctl,
  output cclb_chain_sts_t sts
);

  logic [7:0]           win_q [WIN_DEPTH];
  logic [7:0]           dlm_q [WIN_DEPTH];
  logic [WIN_DEPTH-1:0] ok_v;
  cclb_cell_ctl_t       cell_ctl [WIN_DEPTH];
  logic [WIDX_W-1:0]    rd_idx;
  logic [WCNT_W-1:0]    wcnt_m1;

  for (genvar i = 0; i < WIN_DEPTH; i++) begin : g_cell
    logic [7:0] win_in;
    logic [7:0] dlm_in;
    logic       dsh;

    if (i == 0) begin : g_head
      assign win_in = ctl.dat;
      assign dlm_in = ctl.dat;
    end else begin : g_body
      assign win_in = win_q[i-1];
      assign dlm_in = dlm_q[i-1];
    end

    if (i < MAX_DELIM) begin : g_dlm
      assign dsh = ctl.dlm_sh;
    end else begin : g_nodlm
      assign dsh = 1'b0;
    end

    assign cell_ctl[i] = '{
      win_sh: ctl.win_sh,
      dlm_sh: dsh,
      is_dlm: (WCNT_W'(i) <  WCNT_W'(ctl.dlen)),
      is_par: (WCNT_W'(i) == WCNT_W'(ctl.dlen))
    };

    cclb_cell u_cell (
      .clk    (clk),
      .ctl    (cell_ctl[i]),
      .win_in (win_in),
      .dlm_in (dlm_in),
      .win_q  (win_q[i]),
      .dlm_q  (dlm_q[i]),
      .ok     (ok_v[i])
    );
  end

  // The oldest held byte sits at position count minus one.
  always_comb begin
    wcnt_m1 = ctl.wcnt - WCNT_W'(1);
    if (ctl.wcnt == '0) begin
      rd_idx = '0;
    end else begin
      rd_idx = WIDX_W'(wcnt_m1);
    end
  end

  assign sts = '{
    all_ok:  &ok_v,
    par_dat: win_q[WIDX_W'(ctl.dlen)],
    rd_dat:  win_q[rd_idx]
  };

endmodule

`default_nettype wire

// File: hdl/cclb_lexer.sv
// Lexer sequencer: holds the lookahead byte and the lexer mode, walks each item
// through its emission steps one output byte per cycle while the output is free and
// drives the cell chain. Depends on cclb_pkg.
`default_nettype none

module cclb_lexer import cclb_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            acc,
  input  logic [7:0]      acc_byte,
  input  logic            acc_last,
  output logic            item_stall,
  input  logic            out_free,
  output cclb_chain_ctl_t chain_ctl,
  input  cclb_chain_sts_t chain_sts,
  output cclb_emit_t      emit_o
);

  localparam logic [2:0] M_CODE   = 3'd0;
  localparam logic [2:0] M_LINE   = 3'd1;
  localparam logic [2:0] M_BLOCK  = 3'd2;
  localparam logic [2:0] M_STR    = 3'd3;
  localparam logic [2:0] M_CHAR   = 3'd4;
  localparam logic [2:0] M_RDELIM = 3'd5;
  localparam logic [2:0] M_RAW    = 3'd6;

  localparam logic [1:0] ST_PROC   = 2'd0;
  localparam logic [1:0] ST_SPACE2 = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_FLUSH  = 2'd3;

  function automatic logic word_char(input logic [7:0] ch);
    word_char = ((ch >= CH_0) && (ch <= CH_9)) || ((ch >= CH_UA) && (ch <= CH_UZ)) ||
                ((ch >= CH_LA) && (ch <= CH_LZ)) || (ch == CH_USCORE);
  endfunction

  function automatic logic [7:0] blank(input logic [7:0] ch);
    blank = (ch == CH_NL) ? CH_NL : CH_SP;
  endfunction

  logic [2:0]        mode_r,   mode_nxt;
  logic [7:0]        held_r,   held_nxt;
  logic              held_v_r, held_v_nxt;
  logic              skip_r,   skip_nxt;
  logic [7:0]        ro0_r,    ro0_nxt;
  logic [7:0]        ro1_r,    ro1_nxt;
  logic [DLEN_W-1:0] dlen_r,   dlen_nxt;
  logic [WCNT_W-1:0] wcnt_r,   wcnt_nxt;
  logic              itm_v_r,  itm_v_nxt;
  logic [1:0]        st_r,     st_nxt;
  logic              p2_r,     p2_nxt;
  logic [7:0]        b_r;
  logic              last_r;

  logic       fire;
  logic [7:0] c;
  logic [7:0] n;
  logic [7:0] quote;
  logic       raw_open;
  logic       wcnt_is1;
  logic       emit;
  logic [7:0] e_dat;
  logic       e_ovf;
  logic       call_end;
  logic       item_done;
  logic       stream_end;
  logic       flush_follows;
  logic       fin;
  logic       win_sh;
  logic       dlm_sh;

  assign fire = itm_v_r && out_free;

  always_comb begin
    // The first call of an item works on the held byte with the new byte as
    // lookahead; the second call, on the final item only, on the new byte.
    c        = p2_r ? b_r : held_r;
    n        = p2_r ? CH_NUL : b_r;
    quote    = (mode_r == M_STR) ? CH_DQ : CH_SQ;
    raw_open = (ro0_r == CH_R) && !word_char(ro1_r);
    wcnt_is1 = (wcnt_r == WCNT_W'(1));

    mode_nxt   = mode_r;
    held_nxt   = held_r;
    held_v_nxt = held_v_r;
    skip_nxt   = skip_r;
    ro0_nxt    = ro0_r;
    ro1_nxt    = ro1_r;
    dlen_nxt   = dlen_r;
    wcnt_nxt   = wcnt_r;
    itm_v_nxt  = itm_v_r;
    st_nxt     = st_r;
    p2_nxt     = p2_r;

    emit       = 1'b0;
    e_dat      = CH_SP;
    e_ovf      = 1'b0;
    call_end   = 1'b0;
    item_done  = 1'b0;
    stream_end = 1'b0;
    win_sh     = 1'b0;
    dlm_sh     = 1'b0;

    unique case (st_r)
      ST_PROC: begin
        if (!p2_r && !held_v_r) begin
          call_end = 1'b1;
        end else if (skip_r) begin
          skip_nxt = 1'b0;
          call_end = 1'b1;
        end else begin
          unique case (mode_r)
            M_CODE: begin
              if ((c == CH_SLASH) && ((n == CH_SLASH) || (n == CH_STAR))) begin
                mode_nxt = (n == CH_SLASH) ? M_LINE : M_BLOCK;
                emit     = 1'b1;
                e_dat    = CH_SP;
                skip_nxt = 1'b1;
                st_nxt   = ST_SPACE2;
              end else if (c == CH_DQ) begin
                emit     = 1'b1;
                e_dat    = c;
                call_end = 1'b1;
                if (raw_open) begin
                  mode_nxt = M_RDELIM;
                  dlen_nxt = '0;
                end else begin
                  mode_nxt = M_STR;
                end
              end else if (c == CH_SQ) begin
                emit     = 1'b1;
                e_dat    = c;
                call_end = 1'b1;
                mode_nxt = M_CHAR;
              end else begin
                emit     = 1'b1;
                e_dat    = c;
                call_end = 1'b1;
              end
            end
            M_LINE: begin
              emit     = 1'b1;
              call_end = 1'b1;
              if (c == CH_NL) begin
                mode_nxt = M_CODE;
                e_dat    = CH_NL;
              end else begin
                e_dat    = CH_SP;
              end
            end
            M_BLOCK: begin
              emit = 1'b1;
              if ((c == CH_STAR) && (n == CH_SLASH)) begin
                mode_nxt = M_CODE;
                e_dat    = CH_SP;
                skip_nxt = 1'b1;
                st_nxt   = ST_SPACE2;
              end else begin
                e_dat    = blank(c);
                call_end = 1'b1;
              end
            end
            M_STR, M_CHAR: begin
              emit = 1'b1;
              // A backslash before a NUL lookahead is blanked on its own.
              if ((c == CH_BSL) && (n != CH_NUL)) begin
                e_dat    = CH_SP;
                skip_nxt = 1'b1;
                st_nxt   = ST_SPACE2;
              end else if (c == quote) begin
                mode_nxt = M_CODE;
                e_dat    = c;
                call_end = 1'b1;
              end else begin
                e_dat    = blank(c);
                call_end = 1'b1;
              end
            end
            M_RDELIM: begin
              emit     = 1'b1;
              e_dat    = c;
              call_end = 1'b1;
              if (c == CH_LPAREN) begin
                mode_nxt = M_RAW;
                wcnt_nxt = '0;
              end else if (dlen_r < DLEN_W'(MAX_DELIM)) begin
                dlm_sh   = 1'b1;
                dlen_nxt = dlen_r + DLEN_W'(1);
              end else begin
                e_ovf    = 1'b1;
              end
            end
            M_RAW: begin
              win_sh   = 1'b1;
              wcnt_nxt = wcnt_r + WCNT_W'(1);
              // Once the window would hold a full closer, either release it
              // or blank its oldest byte and slide on.
              if (wcnt_r > WCNT_W'(dlen_r)) begin
                if ((c == CH_DQ) && chain_sts.all_ok) begin
                  mode_nxt = M_CODE;
                  st_nxt   = ST_DRAIN;
                end else begin
                  wcnt_nxt = wcnt_r;
                  emit     = 1'b1;
                  e_dat    = blank(chain_sts.par_dat);
                  call_end = 1'b1;
                end
              end else begin
                call_end = 1'b1;
              end
            end
            default: begin
              mode_nxt = M_CODE;
              emit     = 1'b1;
              e_dat    = c;
              call_end = 1'b1;
            end
          endcase
        end
      end
      ST_SPACE2: begin
        emit     = 1'b1;
        e_dat    = CH_SP;
        call_end = 1'b1;
      end
      ST_DRAIN: begin
        emit     = 1'b1;
        e_dat    = chain_sts.rd_dat;
        wcnt_nxt = wcnt_r - WCNT_W'(1);
        call_end = wcnt_is1;
      end
      ST_FLUSH: begin
        emit     = 1'b1;
        e_dat    = blank(chain_sts.rd_dat);
        wcnt_nxt = wcnt_r - WCNT_W'(1);
        if (wcnt_is1) begin
          item_done  = 1'b1;
          stream_end = 1'b1;
        end
      end
    endcase

    flush_follows = (mode_nxt == M_RAW) && (wcnt_nxt != '0);

    if (call_end) begin
      if (!p2_r) begin
        if (last_r) begin
          p2_nxt = 1'b1;
          st_nxt = ST_PROC;
        end else begin
          item_done = 1'b1;
        end
      end else if (flush_follows) begin
        st_nxt = ST_FLUSH;
      end else begin
        item_done  = 1'b1;
        stream_end = 1'b1;
      end
    end

    // Final byte of the stream: the end of the last call with nothing left
    // to flush, or a first call whose pair skips the final byte.
    fin = last_r && ((call_end && (p2_r ? !flush_follows : skip_nxt)) ||
                     ((st_r == ST_FLUSH) && wcnt_is1));

    if (emit) begin
      ro1_nxt = ro0_r;
      ro0_nxt = e_dat;
    end

    if (item_done) begin
      itm_v_nxt  = 1'b0;
      held_nxt   = b_r;
      held_v_nxt = 1'b1;
      st_nxt     = ST_PROC;
      p2_nxt     = 1'b0;
    end

    if (stream_end) begin
      mode_nxt   = M_CODE;
      held_nxt   = CH_NUL;
      held_v_nxt = 1'b0;
      skip_nxt   = 1'b0;
      ro0_nxt    = CH_NUL;
      ro1_nxt    = CH_NUL;
      dlen_nxt   = '0;
      wcnt_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_CODE;
      held_v_r <= 1'b0;
      skip_r   <= 1'b0;
      ro0_r    <= CH_NUL;
      ro1_r    <= CH_NUL;
      dlen_r   <= '0;
      wcnt_r   <= '0;
      itm_v_r  <= 1'b0;
      st_r     <= ST_PROC;
      p2_r     <= 1'b0;
    end else begin
      if (fire) begin
        mode_r   <= mode_nxt;
        held_v_r <= held_v_nxt;
        skip_r   <= skip_nxt;
        ro0_r    <= ro0_nxt;
        ro1_r    <= ro1_nxt;
        dlen_r   <= dlen_nxt;
        wcnt_r   <= wcnt_nxt;
      end
      // An item is only accepted when none is held or the held one finishes.
      if (acc) begin
        itm_v_r <= 1'b1;
        st_r    <= ST_PROC;
        p2_r    <= 1'b0;
      end else if (fire) begin
        itm_v_r <= itm_v_nxt;
        st_r    <= st_nxt;
        p2_r    <= p2_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      held_r <= held_nxt;
    end
    if (acc) begin
      b_r    <= acc_byte;
      last_r <= acc_last;
    end
  end

  // A new item may enter in the cycle in which the current one finishes.
  assign item_stall = itm_v_r && !(fire && item_done);

  assign chain_ctl = '{
    win_sh: fire && win_sh,
    dlm_sh: fire && dlm_sh,
    dat:    c,
    dlen:   dlen_r,
    wcnt:   wcnt_r
  };

  assign emit_o = '{
    vld:  fire && emit,
    dat:  e_dat,
    last: fin,
    ovf:  e_ovf
  };

endmodule

`default_nettype wire

// File: hdl/cclb_chk.sv
// Port-level checker for the blanker and the bind that attaches it to the top
// level. Depends on cclb_pkg and cpp_comment_literal_blanker.
`default_nettype none

module cclb_chk import cclb_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       out_last,
  input logic       out_delim_overflow
);

  // Leaving reset, no result is shown and the input side is open.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !in_stall))
    else $error("output valid or input stall set after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_byte) &&
                                  $stable(out_last) && $stable(out_delim_overflow)))
    else $error("stalled output item changed");

  // The opening parenthesis ends a delimiter and is never flagged.
  a_ovf_not_paren: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_delim_overflow) |-> (out_byte != CH_LPAREN))
    else $error("overflow flag on the delimiter terminator");

endmodule

bind cpp_comment_literal_blanker cclb_chk u_cclb_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_byte           (out_byte),
  .out_last           (out_last),
  .out_delim_overflow (out_delim_overflow)
);

`default_nettype wire

// File: sim/testbench.sv
// Self-checking testbench for cpp_comment_literal_blanker: C++-like byte streams in,
// blanked stream checked byte for byte against an in-bench model of the lexer.
// Depends on cclb_pkg and the RTL of the block only.

module testbench;
  import cclb_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 50;
  localparam int CALM_FROM    = 20;
  localparam int CALM_TO      = 220;
  localparam int HOLD_AT      = 300;
  localparam int HOLD_LEN     = 300;
  localparam int RANDOM_BYTES = 400;

  typedef enum logic [2:0] {
    MODE_CODE,
    MODE_LINE,
    MODE_BLOCK,
    MODE_STR,
    MODE_CHAR,
    MODE_RDELIM,
    MODE_RAW
  } lex_mode_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } src_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       ovf;
  } blanked_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       in_last = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       out_last;
  logic       out_delim_overflow;

  src_item_t source_q[$];
  blanked_t  blanked_q[$];
  src_item_t next_src;
  blanked_t  got_exp;
  int        total_items;
  int        accepted_cnt = 0;
  int        error_cnt = 0;
  int        cycle_cnt = 0;
  int        rx_cycles = 0;
  int        hold_left = 0;
  logic      calm;

  // Lexer state of the in-bench model.
  lex_mode_e  lex_mode;
  logic [7:0] held_b;
  logic       held_v;
  logic       skip_nxt;
  logic [7:0] prev_out [2];
  logic [7:0] delim_buf [MAX_DELIM];
  int         delim_len;
  logic [7:0] closer_buf [WIN_DEPTH];
  int         closer_cnt;
  int         step_n;

  cpp_comment_literal_blanker dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_byte            (in_byte),
    .in_last            (in_last),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_byte           (out_byte),
    .out_last           (out_last),
    .out_delim_overflow (out_delim_overflow)
  );

  always #5 clk = ~clk;

  function automatic void clear_lexer();
    lex_mode    = MODE_CODE;
    held_b      = 8'h00;
    held_v      = 1'b0;
    skip_nxt    = 1'b0;
    prev_out[0] = 8'h00;
    prev_out[1] = 8'h00;
    delim_len   = 0;
    closer_cnt  = 0;
    for (int k = 0; k < MAX_DELIM; k++) delim_buf[k] = 8'h00;
    for (int k = 0; k < WIN_DEPTH; k++) closer_buf[k] = 8'h00;
  endfunction

  function automatic void queue_blanked(input logic [7:0] b, input logic ovf);
    blanked_t item;
    item = '{data: b, last: 1'b0, ovf: ovf};
    blanked_q = {blanked_q, item};
    prev_out[1] = prev_out[0];
    prev_out[0] = b;
    step_n++;
  endfunction

  function automatic logic [7:0] blank_of(input logic [7:0] c);
    return (c == CH_NL) ? CH_NL : CH_SP;
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return (c >= CH_0 && c <= CH_9) || (c >= CH_UA && c <= CH_UZ) ||
           (c >= CH_LA && c <= CH_LZ) || c == CH_USCORE;
  endfunction

  function automatic logic closer_hit();
    if (closer_buf[0] != CH_RPAREN || closer_buf[delim_len + 1] != CH_DQ) return 1'b0;
    for (int k = 0; k < delim_len; k++)
      if (closer_buf[k + 1] != delim_buf[k]) return 1'b0;
    return 1'b1;
  endfunction

  // One byte c with lookahead n through the lexer.
  function automatic void lex_byte(input logic [7:0] c, input logic [7:0] n);
    logic raw;
    int   span;
    if (skip_nxt) begin
      skip_nxt = 1'b0;
      return;
    end
    case (lex_mode)
      MODE_CODE: begin
        if (c == CH_SLASH && (n == CH_SLASH || n == CH_STAR)) begin
          if (n == CH_SLASH) lex_mode = MODE_LINE;
          else lex_mode = MODE_BLOCK;
          queue_blanked(CH_SP, 1'b0);
          queue_blanked(CH_SP, 1'b0);
          skip_nxt = 1'b1;
        end else if (c == CH_DQ) begin
          raw = (prev_out[0] == CH_R) && !is_word(prev_out[1]);
          queue_blanked(c, 1'b0);
          if (raw) begin
            lex_mode  = MODE_RDELIM;
            delim_len = 0;
          end else begin
            lex_mode = MODE_STR;
          end
        end else if (c == CH_SQ) begin
          queue_blanked(c, 1'b0);
          lex_mode = MODE_CHAR;
        end else begin
          queue_blanked(c, 1'b0);
        end
      end
      MODE_LINE: begin
        if (c == CH_NL) begin
          lex_mode = MODE_CODE;
          queue_blanked(CH_NL, 1'b0);
        end else begin
          queue_blanked(CH_SP, 1'b0);
        end
      end
      MODE_BLOCK: begin
        if (c == CH_STAR && n == CH_SLASH) begin
          lex_mode = MODE_CODE;
          queue_blanked(CH_SP, 1'b0);
          queue_blanked(CH_SP, 1'b0);
          skip_nxt = 1'b1;
        end else begin
          queue_blanked(blank_of(c), 1'b0);
        end
      end
      MODE_STR, MODE_CHAR: begin
        if (c == CH_BSL && n != CH_NUL) begin
          queue_blanked(CH_SP, 1'b0);
          queue_blanked(CH_SP, 1'b0);
          skip_nxt = 1'b1;
        end else if ((lex_mode == MODE_STR && c == CH_DQ) ||
                     (lex_mode == MODE_CHAR && c == CH_SQ)) begin
          lex_mode = MODE_CODE;
          queue_blanked(c, 1'b0);
        end else begin
          queue_blanked(blank_of(c), 1'b0);
        end
      end
      MODE_RDELIM: begin
        if (c == CH_LPAREN) begin
          queue_blanked(c, 1'b0);
          lex_mode   = MODE_RAW;
          closer_cnt = 0;
        end else if (delim_len < MAX_DELIM) begin
          delim_buf[delim_len] = c;
          delim_len++;
          queue_blanked(c, 1'b0);
        end else begin
          queue_blanked(c, 1'b1);
        end
      end
      MODE_RAW: begin
        span = delim_len + 2;
        if (closer_cnt < WIN_DEPTH) begin
          closer_buf[closer_cnt] = c;
          closer_cnt++;
        end
        if (closer_cnt >= span) begin
          if (closer_hit()) begin
            for (int k = 0; k < span; k++) queue_blanked(closer_buf[k], 1'b0);
            closer_cnt = 0;
            lex_mode   = MODE_CODE;
          end else begin
            queue_blanked(blank_of(closer_buf[0]), 1'b0);
            for (int k = 0; k < WIN_DEPTH - 1; k++) closer_buf[k] = closer_buf[k + 1];
            closer_cnt--;
          end
        end
      end
      default: begin
        lex_mode = MODE_CODE;
        queue_blanked(c, 1'b0);
      end
    endcase
  endfunction

  // Expected output bytes for one accepted source byte.
  function automatic void blank_source_byte(input logic [7:0] b, input logic last);
    blanked_t tail;
    step_n = 0;
    if (held_v) lex_byte(held_b, b);
    held_b = b;
    held_v = 1'b1;
    if (last) begin
      lex_byte(b, CH_NUL);
      if (lex_mode == MODE_RAW)
        for (int k = 0; k < closer_cnt; k++) queue_blanked(blank_of(closer_buf[k]), 1'b0);
      if (step_n > 0) begin
        tail = blanked_q.pop_back();
        tail.last = 1'b1;
        blanked_q = {blanked_q, tail};
      end
      clear_lexer();
    end
  endfunction

  // Stimulus construction.
  function automatic void push_src(input logic [7:0] b);
    src_item_t item;
    item = '{data: b, last: 1'b0};
    source_q = {source_q, item};
  endfunction

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_src(s[i]);
  endfunction

  function automatic void close_stream();
    src_item_t tail;
    tail = source_q.pop_back();
    tail.last = 1'b1;
    source_q = {source_q, tail};
  endfunction

  function automatic logic [7:0] pick_word_char();
    case ($urandom_range(3))
      0:       return 8'(CH_0 + $urandom_range(9));
      1:       return 8'(CH_UA + $urandom_range(25));
      2:       return 8'(CH_LA + $urandom_range(25));
      default: return CH_USCORE;
    endcase
  endfunction

  function automatic logic [7:0] pick_text_char();
    case ($urandom_range(9))
      0:       return CH_NL;
      1:       return CH_SP;
      2:       return CH_STAR;
      3:       return CH_SLASH;
      4:       return CH_DQ;
      5:       return CH_SQ;
      6:       return CH_BSL;
      7:       return 8'($urandom_range(255));
      default: return pick_word_char();
    endcase
  endfunction

  function automatic void push_raw_string();
    logic [7:0] dch [24];
    logic [7:0] c;
    int         dl;
    int         part;
    case ($urandom_range(3))
      0:       push_src(pick_word_char());
      1:       push_src(CH_SP);
      default: ;
    endcase
    push_src(CH_R);
    push_src(CH_DQ);
    dl = ($urandom_range(3) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 4);
    for (int i = 0; i < dl; i++) begin
      if ($urandom_range(7) == 0) begin
        do c = 8'($urandom_range(255)); while (c == CH_LPAREN);
      end else begin
        c = pick_word_char();
      end
      dch[i] = c;
      push_src(c);
    end
    push_src(CH_LPAREN);
    // The body mixes plain text with fragments that look like the start of the closer.
    for (int i = $urandom_range(8); i > 0; i--) begin
      case ($urandom_range(4))
        0: push_src(CH_RPAREN);
        1: begin
          push_src(CH_RPAREN);
          part = $urandom_range((dl < MAX_DELIM) ? dl : MAX_DELIM);
          for (int j = 0; j < part; j++) push_src(dch[j]);
        end
        2:       push_src(CH_DQ);
        default: push_src(pick_text_char());
      endcase
    end
    if ($urandom_range(9) != 0) begin
      push_src(CH_RPAREN);
      for (int j = 0; j < dl && j < MAX_DELIM; j++) push_src(dch[j]);
      push_src(CH_DQ);
    end
  endfunction

  function automatic void push_fragment();
    case ($urandom_range(13))
      0, 1: begin
        for (int i = $urandom_range(1, 6); i > 0; i--)
          push_src(($urandom_range(3) == 0) ? CH_R : pick_word_char());
        push_src(($urandom_range(1) == 0) ? CH_SP : CH_NL);
      end
      2, 3: begin
        push_text("//");
        for (int i = $urandom_range(6); i > 0; i--) push_src(pick_text_char());
        if ($urandom_range(3) != 0) push_src(CH_NL);
      end
      4, 5: begin
        push_text("/*");
        for (int i = $urandom_range(8); i > 0; i--) push_src(pick_text_char());
        if ($urandom_range(4) != 0) push_text("*/");
      end
      6, 7: begin
        push_src(CH_DQ);
        for (int i = $urandom_range(6); i > 0; i--) begin
          if ($urandom_range(3) == 0) push_src(CH_BSL);
          push_src(pick_text_char());
        end
        push_src(CH_DQ);
      end
      8: begin
        push_src(CH_SQ);
        if ($urandom_range(1) == 0) push_src(CH_BSL);
        push_src(pick_text_char());
        push_src(CH_SQ);
      end
      9, 10, 11: push_raw_string();
      default:
        for (int i = $urandom_range(1, 4); i > 0; i--) push_src(8'($urandom_range(255)));
    endcase
  endfunction

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  assign calm = (cycle_cnt >= CALM_FROM) && (cycle_cnt < CALM_TO);

  // Source side: feeds queued bytes, holding the payload while the block stalls.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        blank_source_byte(in_byte, in_last);
        accepted_cnt++;
      end
      if (!in_valid || !in_stall) begin
        if (source_q.size() > 0 && (calm || $urandom_range(99) >= 30)) begin
          next_src = source_q.pop_front();
          in_valid <= 1'b1;
          in_byte  <= next_src.data;
          in_last  <= next_src.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result side: checks each accepted byte and drives the stall.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (blanked_q.size() == 0) begin
          $display("%0t: output byte %h with no item expected", $time, out_byte);
          error_cnt++;
        end else begin
          got_exp = blanked_q.pop_front();
          if (out_byte !== got_exp.data) begin
            $display("%0t: out_byte expected %h actual %h", $time, got_exp.data, out_byte);
            error_cnt++;
          end
          if (out_last !== got_exp.last) begin
            $display("%0t: out_last expected %b actual %b", $time, got_exp.last, out_last);
            error_cnt++;
          end
          if (out_delim_overflow !== got_exp.ovf) begin
            $display("%0t: out_delim_overflow expected %b actual %b", $time, got_exp.ovf,
                     out_delim_overflow);
            error_cnt++;
          end
        end
      end
      // A long hold-off fills the block so that it has to stall its input.
      rx_cycles <= rx_cycles + 1;
      if (rx_cycles == HOLD_AT) hold_left <= HOLD_LEN;
      else if (hold_left > 0) hold_left <= hold_left - 1;
      if (hold_left > 0 || rx_cycles == HOLD_AT) out_stall <= 1'b1;
      else if (calm) out_stall <= 1'b0;
      else out_stall <= ($urandom_range(99) < 30);
    end
  end

  initial begin
    clear_lexer();
    // Comments, a plain string with an escape, a char literal and an empty-delimiter raw string.
    push_text("a//\n/**/\"\\x\"'y'R\"(b)\"");
    close_stream();
    // A backslash before a real NUL byte, then a backslash that ends the stream.
    push_src(CH_DQ);
    push_src(CH_BSL);
    push_src(CH_NUL);
    push_src(CH_BSL);
    close_stream();
    push_src(8'hFF);
    close_stream();
    while (source_q.size() < 26 + RANDOM_BYTES) begin
      for (int i = $urandom_range(1, 8); i > 0; i--) push_fragment();
      close_stream();
    end
    total_items = source_q.size();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk); while (accepted_cnt != total_items || blanked_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (error_cnt == 0 && blanked_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
